// File: rtl/pdfs_pkg.sv
// Shared types and constants for the pulse-distance frame sender.
package pdfs_pkg;

    localparam int DATA_BITS   = 6;
    localparam int PIN_COUNT   = 6;
    localparam int PIN_BASE    = 6;
    localparam int TIMER_W     = 24;
    localparam int PREAMBLE_W  = 4;
    localparam int PULSE_IDX_W = 5;
    localparam int CHANNEL_W   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = TIMER_W;
    localparam int PIN_SEL_W   = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

    localparam logic [TIMER_W-1:0]    HIGH_TICKS_RST  = TIMER_W'(906);
    localparam logic [TIMER_W-1:0]    SHORT_GAP_RST   = TIMER_W'(5000);
    localparam logic [TIMER_W-1:0]    LONG_GAP_RST    = TIMER_W'(7000);
    localparam logic [PREAMBLE_W-1:0] PREAMBLE_RST    = PREAMBLE_W'(5);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HIGH_TICKS      = 2'd0,
        CFG_SHORT_GAP_TICKS = 2'd1,
        CFG_LONG_GAP_TICKS  = 2'd2,
        CFG_PREAMBLE_PULSES = 2'd3
    } cfg_index_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_SEND = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_TICK        = 2'd0,
        ST_ACCEPTED    = 2'd1,
        ST_REJ_BUSY    = 2'd2,
        ST_REJ_CHANNEL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        kind_t                kind;
        logic [CHANNEL_W-1:0] channel;
        logic [DATA_BITS-1:0] command;
    } in_item_t;

    typedef struct packed {
        logic [PIN_COUNT-1:0] pin_drive;
        logic                 busy_res;
        status_t              status;
    } out_item_t;

endpackage

// File: rtl/pulse_distance_frame_sender.sv
// Pulse-distance frame sender: frame sequencer, timing registers and result skid buffer.
// One transaction in gives one transaction out. A tick (kind 0) advances the pulse timer by
// one; a send (kind 1) starts a frame on pin channel-6 when the sequencer is idle and the channel
// is 6..11, otherwise it is rejected with a status code and nothing changes. A frame is a run
// of preamble pulses with short gaps, then the command bits MSB first (long gap for a 1,
// short gap for a 0), then a last pulse with no gap. Each result shows pin levels and busy
// after its item. The block takes one transaction per clock while the skid register is empty;
// each result goes to the result register, or to the skid register while the output stalls.
// The cycle is set by the 24-bit timer increment and compare against the selected timing
// register. A two-entry output (result plus skid register) takes one more transaction while
// the output stalls. Timing registers are written through cfg_we/cfg_index/cfg_data and must
// only change while no transaction is outstanding; a timing value of zero behaves as one.
module pulse_distance_frame_sender (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  pdfs_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pdfs_pkg::out_item_t              out_data,
    input  logic                             cfg_we,
    input  logic [pdfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pdfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pdfs_pkg::*;

    // configuration
    logic [TIMER_W-1:0]    high_ticks_reg;
    logic [TIMER_W-1:0]    short_gap_reg;
    logic [TIMER_W-1:0]    long_gap_reg;
    logic [PREAMBLE_W-1:0] preamble_reg;

    // sequencer state
    phase_t                 phase_reg, phase_next;
    logic [PULSE_IDX_W-1:0] pulse_index_reg, pulse_index_next;
    logic [TIMER_W-1:0]     tick_count_reg, tick_count_next;
    logic [DATA_BITS-1:0]   data_shift_reg, data_shift_next;
    logic [PIN_SEL_W-1:0]   pin_select_reg, pin_select_next;

    // output side
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_data_reg, out_data_next;
    out_item_t skid_data_reg, skid_data_next;

    logic               in_fire;
    logic               out_take;
    status_t            status;
    out_item_t          result;
    logic [TIMER_W-1:0] tick_inc;
    logic [TIMER_W-1:0] gap_ticks;
    logic [PULSE_IDX_W:0] last_pulse;
    logic [CHANNEL_W:0]   chan_off;
    logic                 chan_ok;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_ticks_reg <= HIGH_TICKS_RST;
            short_gap_reg  <= SHORT_GAP_RST;
            long_gap_reg   <= LONG_GAP_RST;
            preamble_reg   <= PREAMBLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HIGH_TICKS:      high_ticks_reg <= cfg_data;
                CFG_SHORT_GAP_TICKS: short_gap_reg  <= cfg_data;
                CFG_LONG_GAP_TICKS:  long_gap_reg   <= cfg_data;
                CFG_PREAMBLE_PULSES: preamble_reg   <= cfg_data[PREAMBLE_W-1:0];
                default: ;
            endcase
        end
    end

    // shared timer datapath
    assign tick_inc   = tick_count_reg + TIMER_W'(1);
    assign last_pulse = (PULSE_IDX_W+1)'(preamble_reg) + (PULSE_IDX_W+1)'(DATA_BITS);
    // preamble pulses and zero bits use the short gap, one bits the long gap
    assign gap_ticks  = ({1'b0, pulse_index_reg} < (PULSE_IDX_W+1)'(preamble_reg)) ?
                        short_gap_reg :
                        (data_shift_reg[DATA_BITS-1] ? long_gap_reg : short_gap_reg);

    // channel range check: PIN_BASE .. PIN_BASE+PIN_COUNT-1
    assign chan_off = {1'b0, in_data.channel} - (CHANNEL_W+1)'(PIN_BASE);
    assign chan_ok  = ({1'b0, in_data.channel} >= (CHANNEL_W+1)'(PIN_BASE)) &&
                      (chan_off < (CHANNEL_W+1)'(PIN_COUNT));

    // next state and result
    always_comb
    begin
        phase_next       = phase_reg;
        pulse_index_next = pulse_index_reg;
        tick_count_next  = tick_count_reg;
        data_shift_next  = data_shift_reg;
        pin_select_next  = pin_select_reg;
        status           = ST_TICK;

        if (in_fire)
        begin
            if (in_data.kind == KIND_TICK)
            begin
                unique case (phase_reg)
                    PH_HIGH:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= high_ticks_reg || tick_inc == '0)
                        begin
                            tick_count_next = '0;
                            // final pulse has no gap
                            if ({1'b0, pulse_index_reg} >= last_pulse)
                                phase_next = PH_IDLE;
                            else
                                phase_next = PH_LOW;
                        end
                    end
                    PH_LOW:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= gap_ticks || tick_inc == '0)
                        begin
                            tick_count_next = '0;
                            if ({1'b0, pulse_index_reg} >= (PULSE_IDX_W+1)'(preamble_reg))
                                data_shift_next = data_shift_reg << 1;
                            pulse_index_next = pulse_index_reg + PULSE_IDX_W'(1);
                            phase_next       = PH_HIGH;
                        end
                    end
                    default: ;
                endcase
            end
            else if (!chan_ok)
            begin
                status = ST_REJ_CHANNEL;
            end
            else if (phase_reg != PH_IDLE)
            begin
                status = ST_REJ_BUSY;
            end
            else
            begin
                status           = ST_ACCEPTED;
                pin_select_next  = chan_off[PIN_SEL_W-1:0];
                data_shift_next  = in_data.command;
                pulse_index_next = '0;
                tick_count_next  = '0;
                phase_next       = PH_HIGH;
            end
        end

        result.pin_drive = (phase_next == PH_HIGH) ?
                           (PIN_COUNT'(1) << pin_select_next) : '0;
        result.busy_res  = (phase_next != PH_IDLE);
        result.status    = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            pulse_index_reg <= '0;
            tick_count_reg  <= '0;
            data_shift_reg  <= '0;
            pin_select_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pulse_index_reg <= pulse_index_next;
            tick_count_reg  <= tick_count_next;
            data_shift_reg  <= data_shift_next;
            pin_select_reg  <= pin_select_next;
        end
    end

    // result register + skid register; skid drains into the result register first
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_pin_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(out_data_reg.pin_drive))
        else $error("more than one pin driven");

    a_pin_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.pin_drive != '0) |-> out_data_reg.busy_res)
        else $error("pin driven outside a frame");

    a_accept_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && status == ST_ACCEPTED) |=> (phase_reg == PH_HIGH && tick_count_reg == '0))
        else $error("accepted send did not start a pulse");

    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_count_reg == '0))
        else $error("timer not cleared while idle");

endmodule
